// ===== sv/rgb_median3x3_invert_filter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RGB_MEDIAN3X3_INVERT_FILTER_DEFINES_SVH
`define RGB_MEDIAN3X3_INVERT_FILTER_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define RMI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define RMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rmi_pkg.sv =====
package rmi_pkg;

	// Configuration register map
	localparam int REG_IDX_BITS = 1;
	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	localparam reg_idx_t REG_WIDTH  = 1'b0;
	localparam reg_idx_t REG_HEIGHT = 1'b1;

	localparam int CFG_DATA_BITS = 16;
	localparam int WIDTH_BITS    = 11;
	localparam int HEIGHT_BITS   = 16;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1;

	// Input item kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam int OUT_BITS = 8;

	// Queue between front and back
	localparam int QDEPTH    = 4;
	localparam int QLVL_BITS = $clog2(QDEPTH + 1);

	// What the back must do with one queued item
	typedef struct packed {
		logic flush;   // drain tick, else pixel
		logic first;   // first column of a row: window reloads
		logic emit_a;  // pixel: emit the shifted window
		logic emit_b;  // pixel: emit the right-edge window (row end)
		logic last;    // drain: final column of the image
	} rmi_ctl_t;

	// Side flags of one result
	typedef struct packed {
		logic run_last;
		logic row_end;
		logic image_end;
	} rmi_flags_t;

endpackage

// ===== sv/rgb_median3x3_invert_filter.sv =====
// 3x3 median filter with inversion, RGB, edge pixels replicated at the border.
// Pixel channel (pix_valid/pix_ready): action 0 carries a pixel in raster order,
// action 1 is a flush tick. Results (res_valid/res_ready) come one row behind:
// each pixel of row r>0 releases the result left of it, the last pixel of a row
// also the row's last result. After the final row, one flush per result drains
// it; image_end marks the last one and a new image may start. Stray pixels
// during the drain and stray flushes give nothing.
// Registers: index 0 image width (1..MAX_WIDTH), index 1 image height; write
// them only while nothing is in flight.
// A result passes the row store read, the queue, the median stages and the
// output register; the second result of a row end follows the first.
// Throughput: one item per cycle at the input while pix_ready is high. The back
// issues a second result on a row end before it takes the next queued item, so
// it falls behind the input on every row of w >= 2 pixels; the four-entry queue
// hides this over a few rows, after that pix_ready drops about once per row.
// Reset clears position, drain state, queue and pipeline; width resets to 1024
// and height to 1. Row stores are not cleared.
// When a result waits with res_ready low, the back pipeline holds and the queue
// fills; pix_ready drops once the queue has no room.
module rgb_median3x3_invert_filter import rmi_pkg::*; #(
	parameter int MAX_WIDTH    = 1024,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_en,
	input  reg_idx_t                  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  logic                      action,
	input  logic [CHANNEL_BITS-1:0]   red_in,
	input  logic [CHANNEL_BITS-1:0]   green_in,
	input  logic [CHANNEL_BITS-1:0]   blue_in,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [OUT_BITS-1:0]       red_out,
	output logic [OUT_BITS-1:0]       green_out,
	output logic [OUT_BITS-1:0]       blue_out,
	output logic                      run_last,
	output logic                      row_end,
	output logic                      image_end
);

	localparam int CB  = CHANNEL_BITS;
	localparam int QW  = $bits(rmi_ctl_t) + 18 * CB;

	logic [2:0][CB-1:0]       px;
	logic [QLVL_BITS-1:0]     q_level;
	logic                     q_push;
	rmi_ctl_t                 push_ctl;
	logic [2:0][2:0][CB-1:0]  push_a, push_b;
	logic [QW-1:0]            q_rdata;
	logic                     q_valid;
	logic                     q_pop;
	rmi_ctl_t                 head_ctl;
	logic [2:0][2:0][CB-1:0]  head_a, head_b;
	logic [2:0][OUT_BITS-1:0] res_px;
	rmi_flags_t               res_flags;

	assign px = {blue_in, green_in, red_in};

	rmi_front #(.MAX_WIDTH(MAX_WIDTH), .CB(CB)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.action    (action),
		.px        (px),
		.q_level   (q_level),
		.q_push    (q_push),
		.q_ctl     (push_ctl),
		.q_col_a   (push_a),
		.q_col_b   (push_b)
	);

	rmi_fifo #(.W(QW), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({push_ctl, push_a, push_b}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid),
		.level  (q_level)
	);

	assign {head_ctl, head_a, head_b} = q_rdata;

	rmi_back #(.CB(CB)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ctl     (head_ctl),
		.q_col_a   (head_a),
		.q_col_b   (head_b),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_px    (res_px),
		.res_flags (res_flags)
	);

	assign red_out   = res_px[0];
	assign green_out = res_px[1];
	assign blue_out  = res_px[2];
	assign run_last  = res_flags.run_last;
	assign row_end   = res_flags.row_end;
	assign image_end = res_flags.image_end;

endmodule

// ===== sv/rmi_ram.sv =====
module rmi_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [W-1:0]                           rdata_a,
	output logic [W-1:0]                           rdata_b
);

	logic [W-1:0] mem [DEPTH];

	// One write port, two registered read ports, read-first
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== sv/rmi_fifo.sv =====
module rmi_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic                         valid,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [LW-1:0] cnt_q;

	assign rdata = mem_q[rd_q];
	assign valid = (cnt_q != '0);
	assign level = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + LW'(1);
				2'b01:   cnt_q <= cnt_q - LW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/rmi_front.sv =====
module rmi_front import rmi_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int CB        = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_en,
	input  reg_idx_t                  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  logic                      action,
	input  logic [2:0][CB-1:0]        px,
	input  logic [QLVL_BITS-1:0]      q_level,
	output logic                      q_push,
	output rmi_ctl_t                  q_ctl,
	output logic [2:0][2:0][CB-1:0]   q_col_a,
	output logic [2:0][2:0][CB-1:0]   q_col_b
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW  = AW + 1;
	localparam int PXW = 3 * CB;

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [HEIGHT_BITS-1:0] row_q;
	logic [AW-1:0]          col_q;
	logic [AW-1:0]          dcol_q;
	logic                   drain_q;
	logic                   par_q;

	logic                   v_s1;
	rmi_ctl_t               ctl_s1;
	logic                   older_s1;
	logic                   par_s1;
	logic [2:0][CB-1:0]     px_s1;

	logic [CW-1:0]          w_eff;
	logic [HEIGHT_BITS-1:0] h_eff;
	logic [CW-1:0]          col_nx;
	logic [CW-1:0]          dcol_nx;
	logic [HEIGHT_BITS:0]   row_nx;
	logic                   row_last;
	logic                   d_last;
	logic                   img_last_row;
	logic                   is_flush;
	logic                   fire;
	logic                   we;
	logic                   push_d;
	logic                   use_older;
	rmi_ctl_t               ctl_d;
	logic [AW-1:0]          addr_a;
	logic [AW-1:0]          addr_b;
	logic [PXW-1:0]         rd0_a, rd0_b, rd1_a, rd1_b;
	logic [2:0][CB-1:0]     old_a, new_a, old_b, new_b;

	// effective image size, clamped into range
	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
	end
	assign h_eff = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;

	// position tests
	assign col_nx       = {1'b0, col_q} + CW'(1);
	assign dcol_nx      = {1'b0, dcol_q} + CW'(1);
	assign row_nx       = {1'b0, row_q} + (HEIGHT_BITS+1)'(1);
	assign row_last     = (col_nx >= w_eff);
	assign d_last       = (dcol_nx >= w_eff);
	assign img_last_row = (row_nx >= {1'b0, h_eff});
	assign is_flush     = (action == ACT_FLUSH);

	assign pix_ready = (({1'b0, q_level} + (QLVL_BITS+1)'(v_s1)) < (QLVL_BITS+1)'(QDEPTH));
	assign fire      = pix_valid && pix_ready;
	assign we        = fire && !is_flush && !drain_q;

	// classify the item and pick row store addresses
	always_comb begin
		if (is_flush) begin
			if (dcol_q == '0) begin
				addr_a = '0;
			end else if (d_last) begin
				addr_a = dcol_q;
			end else begin
				addr_a = dcol_nx[AW-1:0];
			end
			addr_b    = d_last ? '0 : AW'(1);
			push_d    = fire && drain_q;
			use_older = (h_eff > 16'd1);
		end else begin
			addr_a    = col_q;
			addr_b    = col_q;
			push_d    = fire && !drain_q && (row_q != '0);
			use_older = (row_q > 16'd1);
		end
		ctl_d.flush  = is_flush;
		ctl_d.first  = is_flush ? (dcol_q == '0) : (col_q == '0);
		ctl_d.emit_a = !is_flush && (col_q != '0);
		ctl_d.emit_b = !is_flush && row_last;
		ctl_d.last   = is_flush && d_last;
	end

	// two row banks; the bank of the current row holds the row two above
	rmi_ram #(.W(PXW), .DEPTH(MAX_WIDTH)) u_bank0 (
		.clk     (clk),
		.we      (we && !par_q),
		.waddr   (col_q),
		.wdata   (px),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd0_a),
		.rdata_b (rd0_b)
	);

	rmi_ram #(.W(PXW), .DEPTH(MAX_WIDTH)) u_bank1 (
		.clk     (clk),
		.we      (we && par_q),
		.waddr   (col_q),
		.wdata   (px),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd1_a),
		.rdata_b (rd1_b)
	);

	// position state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
			dcol_q   <= '0;
			drain_q  <= 1'b0;
			par_q    <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			if (cfg_en) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
					REG_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
					default:    ;
				endcase
			end
			v_s1 <= push_d;
			if (fire) begin
				if (is_flush) begin
					if (drain_q) begin
						if (d_last) begin
							drain_q <= 1'b0;
							dcol_q  <= '0;
							row_q   <= '0;
							col_q   <= '0;
						end else begin
							dcol_q <= dcol_nx[AW-1:0];
						end
					end
				end else if (!drain_q) begin
					if (row_last) begin
						col_q <= '0;
						par_q <= ~par_q;
						if (img_last_row) begin
							drain_q <= 1'b1;
							dcol_q  <= '0;
						end else begin
							row_q <= row_nx[HEIGHT_BITS-1:0];
						end
					end else begin
						col_q <= col_nx[AW-1:0];
					end
				end
			end
		end
	end

	// item side data, registered to meet the row store read
	always_ff @(posedge clk) begin
		ctl_s1   <= ctl_d;
		older_s1 <= use_older;
		par_s1   <= par_q;
		px_s1    <= px;
	end

	// assemble window columns
	assign old_a = par_s1 ? rd1_a : rd0_a;
	assign new_a = par_s1 ? rd0_a : rd1_a;
	assign old_b = par_s1 ? rd1_b : rd0_b;
	assign new_b = par_s1 ? rd0_b : rd1_b;

	assign q_push     = v_s1;
	assign q_ctl      = ctl_s1;
	assign q_col_a[0] = older_s1 ? old_a : new_a;
	assign q_col_a[1] = new_a;
	assign q_col_a[2] = ctl_s1.flush ? new_a : px_s1;
	assign q_col_b[0] = older_s1 ? old_b : new_b;
	assign q_col_b[1] = new_b;
	assign q_col_b[2] = new_b;

endmodule

// ===== sv/rmi_back.sv =====
module rmi_back import rmi_pkg::*; #(
	parameter int CB = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  rmi_ctl_t                 q_ctl,
	input  logic [2:0][2:0][CB-1:0]  q_col_a,
	input  logic [2:0][2:0][CB-1:0]  q_col_b,
	output logic                     q_pop,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [2:0][OUT_BITS-1:0] res_px,
	output rmi_flags_t               res_flags
);

	// window: [column][row][channel]
	logic [2:0][2:0][2:0][CB-1:0] win_q;
	logic                         pend_b_q;
	logic [2:0][2:0][2:0][CB-1:0] win_nx;
	logic [2:0][2:0][2:0][CB-1:0] edge_nx;
	logic [2:0][2:0][2:0][CB-1:0] edge_q;
	logic [2:0][2:0][2:0][CB-1:0] job_win;
	rmi_flags_t                   job_fl;
	logic                         job_v;
	logic                         pend_d;
	logic                         pop_d;
	logic                         adv;

	logic                         v_s1, v_s2, v_s3;
	logic [2:0][2:0][2:0][CB-1:0] win_s1;
	rmi_flags_t                   fl_s1, fl_s2, fl_s3;
	logic [2:0][2:0][2:0][CB-1:0] srt_s2;  // [column][channel][rank]
	logic [2:0][2:0][CB-1:0]      trio_s3; // [channel][lo-max, mid-med, hi-min]
	logic [2:0][2:0][2:0][CB-1:0] srt_d;
	logic [2:0][2:0][CB-1:0]      trio_d;
	logic [2:0][CB-1:0]           inv_d;
	logic [2:0][OUT_BITS-1:0]     out_d;
	logic                         res_valid_q;
	logic [2:0][OUT_BITS-1:0]     res_px_q;
	rmi_flags_t                   res_fl_q;

	function automatic logic [CB-1:0] vmin(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [CB-1:0] vmax(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [CB-1:0] med3(input logic [CB-1:0] a, input logic [CB-1:0] b,
			input logic [CB-1:0] c);
		return vmax(vmin(a, b), vmin(vmax(a, b), c));
	endfunction

	// returns {hi, mid, lo}
	function automatic logic [2:0][CB-1:0] sort3(input logic [CB-1:0] a,
			input logic [CB-1:0] b, input logic [CB-1:0] c);
		logic [CB-1:0] l1, h1, t;
		logic [2:0][CB-1:0] r;
		l1   = vmin(a, b);
		h1   = vmax(a, b);
		t    = vmax(l1, c);
		r[0] = vmin(l1, c);
		r[1] = vmin(t, h1);
		r[2] = vmax(t, h1);
		return r;
	endfunction

	assign adv = !res_valid_q || res_ready;

	// next window and its right-edge variant
	always_comb begin
		if (q_ctl.first) begin
			win_nx[0] = q_col_a;
			win_nx[1] = q_col_a;
			win_nx[2] = q_ctl.flush ? q_col_b : q_col_a;
		end else begin
			win_nx[0] = win_q[1];
			win_nx[1] = win_q[2];
			win_nx[2] = q_col_a;
		end
		edge_nx = {win_nx[2], win_nx[2], win_nx[1]};
		edge_q  = {win_q[2], win_q[2], win_q[1]};
	end

	// issue up to two median jobs per queued item
	always_comb begin
		job_v   = 1'b0;
		job_win = win_nx;
		job_fl  = '0;
		pend_d  = pend_b_q;
		pop_d   = 1'b0;
		if (pend_b_q) begin
			job_v          = 1'b1;
			job_win        = edge_q;
			job_fl.row_end = 1'b1;
			job_fl.run_last = 1'b1;
			pend_d         = 1'b0;
		end else if (q_valid) begin
			pop_d = 1'b1;
			if (q_ctl.flush) begin
				job_v            = 1'b1;
				job_fl.row_end   = q_ctl.last;
				job_fl.image_end = q_ctl.last;
				job_fl.run_last  = 1'b1;
			end else if (q_ctl.emit_a) begin
				job_v           = 1'b1;
				job_fl.run_last = !q_ctl.emit_b;
				pend_d          = q_ctl.emit_b;
			end else if (q_ctl.emit_b) begin
				job_v           = 1'b1;
				job_win         = edge_nx;
				job_fl.row_end  = 1'b1;
				job_fl.run_last = 1'b1;
			end
		end
	end

	assign q_pop = adv && pop_d;

	// median network: sort columns, then combine
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int ch = 0; ch < 3; ch++) begin
				srt_d[c][ch] = sort3(win_s1[c][0][ch], win_s1[c][1][ch], win_s1[c][2][ch]);
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			trio_d[ch][0] = vmax(vmax(srt_s2[0][ch][0], srt_s2[1][ch][0]), srt_s2[2][ch][0]);
			trio_d[ch][1] = med3(srt_s2[0][ch][1], srt_s2[1][ch][1], srt_s2[2][ch][1]);
			trio_d[ch][2] = vmin(vmin(srt_s2[0][ch][2], srt_s2[1][ch][2]), srt_s2[2][ch][2]);
			// invert at channel width, then fit to the output width
			inv_d[ch]     = ~med3(trio_s3[ch][0], trio_s3[ch][1], trio_s3[ch][2]);
			out_d[ch]     = OUT_BITS'(inv_d[ch]);
		end
	end

	// control: pending edge job and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_b_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			pend_b_q    <= pend_d;
			v_s1        <= job_v;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	// window and pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop_d) begin
				win_q <= win_nx;
			end
			win_s1   <= job_win;
			fl_s1    <= job_fl;
			srt_s2   <= srt_d;
			fl_s2    <= fl_s1;
			trio_s3  <= trio_d;
			fl_s3    <= fl_s2;
			res_px_q <= out_d;
			res_fl_q <= fl_s3;
		end
	end

	assign res_valid = res_valid_q;
	assign res_px    = res_px_q;
	assign res_flags = res_fl_q;

endmodule

// ===== sv/rmi_checker.sv =====
`include "rgb_median3x3_invert_filter_defines.svh"

module rmi_checker import rmi_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic [OUT_BITS-1:0] red_out,
	input logic [OUT_BITS-1:0] green_out,
	input logic [OUT_BITS-1:0] blue_out,
	input logic                run_last,
	input logic                row_end,
	input logic                image_end
);

	// a stalled result stays offered
	`RMI_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// a stalled result keeps its pixel
	`RMI_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(red_out) && $stable(green_out) && $stable(blue_out), "result changed while stalled")

	// the image's last result also closes its row
	`RMI_ASSERT_SAME(a_img_row, clk, arst_n, res_valid && image_end, row_end, "image end without row end")

	// nothing follows a row-ending result within the same item
	`RMI_ASSERT_SAME(a_row_run, clk, arst_n, res_valid && row_end, run_last, "row end not last of its item")

endmodule

bind rgb_median3x3_invert_filter rmi_checker u_chk (.*);

// ===== test/tb_rgb_median3x3_invert_filter.sv =====
`timescale 1ns / 100ps

module tb_rgb_median3x3_invert_filter;
	import rmi_pkg::*;

	localparam int MAX_W      = 1024;
	localparam int STALL_MAX  = 3000;

	typedef logic [23:0] pixel_t;            // {blue, green, red}
	typedef logic [2:0][23:0] column_t;      // [0] top .. [2] bottom
	typedef logic [2:0][2:0][23:0] window_t; // [column][row]

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       run_last;
		logic       row_end;
		logic       image_end;
	} filt_result_t;

	logic clk;
	logic arst_n;
	logic cfg_en;
	reg_idx_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic pix_valid;
	logic pix_ready;
	logic action;
	logic [7:0] red_in, green_in, blue_in;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [7:0] red_out, green_out, blue_out;
	logic run_last, row_end, image_end;

	// Predictor state
	pixel_t older_px [MAX_W];
	pixel_t newer_px [MAX_W];
	window_t win_cols;
	int unsigned in_row, in_col, drain_col;
	bit drain_on;
	logic [WIDTH_BITS-1:0]  width_reg;
	logic [HEIGHT_BITS-1:0] height_reg;

	filt_result_t expected_results [$];
	int errors = 0;
	int stall_cycles = 0;
	bit calm;

	rgb_median3x3_invert_filter DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .action(action),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.res_valid(res_valid), .res_ready(res_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.run_last(run_last), .row_end(row_end), .image_end(image_end)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic logic [7:0] channel_median(window_t w, int ch);
		logic [7:0] v [9];
		logic [7:0] t;
		int n;
		n = 0;
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++) begin
				v[n] = w[c][r][ch*8 +: 8];
				n++;
			end
		for (int i = 0; i < 9; i++)
			for (int j = 0; j < 8 - i; j++)
				if (v[j] > v[j+1]) begin
					t = v[j];
					v[j] = v[j+1];
					v[j+1] = t;
				end
		return v[4];
	endfunction

	function automatic filt_result_t inverted_median(window_t w, bit rend, bit iend);
		filt_result_t res;
		res.red       = 8'd255 - channel_median(w, 0);
		res.green     = 8'd255 - channel_median(w, 1);
		res.blue      = 8'd255 - channel_median(w, 2);
		res.run_last  = 1'b0;
		res.row_end   = rend;
		res.image_end = iend;
		return res;
	endfunction

	// Column of the final row: top from the row above, bottom replicated
	function automatic column_t final_row_column(int unsigned x);
		column_t col;
		int unsigned i;
		i = (x < MAX_W) ? x : MAX_W - 1;
		col[1] = newer_px[i];
		col[2] = newer_px[i];
		col[0] = (eff_height() >= 2) ? older_px[i] : newer_px[i];
		return col;
	endfunction

	// Expected results of one accepted item
	task automatic predict_item(input logic act, input logic [7:0] r, g, b);
		filt_result_t outs [$];
		window_t w;
		column_t col;
		pixel_t px;
		int unsigned wd, ht, d, c, i;
		bit last;
		wd = eff_width();
		ht = eff_height();
		if (act == ACT_FLUSH) begin
			if (!drain_on) return;
			d = drain_col;
			last = (d + 1 >= wd);
			w[0] = final_row_column(d == 0 ? 0 : d - 1);
			w[1] = final_row_column(d);
			w[2] = final_row_column(last ? d : d + 1);
			outs = {outs, inverted_median(w, last, last)};
			if (last) begin
				drain_on = 0;
				drain_col = 0;
				in_row = 0;
				in_col = 0;
			end else begin
				drain_col = d + 1;
			end
		end else begin
			if (drain_on) return;
			c = in_col;
			i = (c < MAX_W) ? c : MAX_W - 1;
			last = (c + 1 >= wd);
			px = {b, g, r};
			col[1] = newer_px[i];
			col[2] = px;
			col[0] = (in_row >= 2) ? older_px[i] : newer_px[i];
			older_px[i] = newer_px[i];
			newer_px[i] = px;
			if (c == 0) begin
				win_cols[0] = col;
				win_cols[1] = col;
				win_cols[2] = col;
			end else begin
				win_cols[0] = win_cols[1];
				win_cols[1] = win_cols[2];
				win_cols[2] = col;
			end
			if (in_row >= 1) begin
				if (c >= 1) outs = {outs, inverted_median(win_cols, 0, 0)};
				if (last) begin
					w[0] = win_cols[1];
					w[1] = win_cols[2];
					w[2] = win_cols[2];
					outs = {outs, inverted_median(w, 1, 0)};
				end
			end
			if (last) begin
				in_col = 0;
				if (in_row + 1 >= ht) begin
					drain_on = 1;
					drain_col = 0;
				end else begin
					in_row = in_row + 1;
				end
			end else begin
				in_col = c + 1;
			end
		end
		if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
		foreach (outs[k]) expected_results = {expected_results, outs[k]};
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Send one item, sometimes after an idle pause unless calm
	task automatic send_item(input logic act, input logic [7:0] r, g, b);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 30) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		action    <= act;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		do @(posedge clk); while (!pix_ready);
		predict_item(act, r, g, b);
	endtask

	task automatic send_pixel(input logic [7:0] r, g, b);
		send_item(ACT_PIXEL, r, g, b);
	endtask

	task automatic send_flush();
		send_item(ACT_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// Stop sending and let every pending result come out
	task automatic wait_idle();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (expected_results.size() > 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_WIDTH) width_reg = val[WIDTH_BITS-1:0];
		else height_reg = val;
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_rand_pixel();
		send_pixel(rand_chan(), rand_chan(), rand_chan());
	endtask

	// One whole image at the current setting, with stray items mixed in
	task automatic send_image(input int noise_pct);
		int unsigned n;
		n = eff_width() * eff_height();
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < noise_pct) send_flush();
			send_rand_pixel();
		end
		while (drain_on) begin
			if ($urandom_range(0, 99) < noise_pct) send_rand_pixel();
			send_flush();
		end
	endtask

	// Extremes, stray items, width one, out-of-range registers
	task automatic test_directed();
		write_reg(REG_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'd3);
		send_flush();
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd127, 8'd1);
		send_pixel(8'd254, 8'd1, 8'd128);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd7, 8'd7, 8'd7);
		send_flush();
		send_flush();
		send_flush();
		send_flush();
		wait_idle();
		// width 0 counts as one, height 0 as one
		write_reg(REG_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		send_pixel(8'd10, 8'd20, 8'd30);
		send_flush();
		wait_idle();
		write_reg(REG_WIDTH, 16'd1);
		write_reg(REG_HEIGHT, 16'd2);
		send_pixel(8'd255, 8'd0, 8'd90);
		send_pixel(8'd0, 8'd255, 8'd91);
		send_flush();
		wait_idle();
	endtask

	// Height lowered mid-image: the current row becomes the last
	task automatic test_height_change();
		write_reg(REG_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'hFFFF);
		repeat (6) send_rand_pixel();
		wait_idle();
		write_reg(REG_HEIGHT, 16'd1);
		repeat (3) send_rand_pixel();
		repeat (3) send_flush();
		wait_idle();
	endtask

	// Random images, small mostly; first stretch without idling
	task automatic test_random_images();
		int sent;
		int unsigned wd, ht;
		sent = 0;
		calm = 1;
		while (sent < 780) begin
			if (sent > 200) calm = 0;
			wd = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			ht = $urandom_range(1, 5);
			write_reg(REG_WIDTH, 16'(wd));
			write_reg(REG_HEIGHT, 16'(ht));
			send_image(8);
			sent += wd * ht + wd;
			wait_idle();
		end
		calm = 0;
	endtask

	// Drive the receive side
	always @(negedge clk) begin
		res_ready <= calm || ($urandom_range(0, 99) >= 24);
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		filt_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$display("MISMATCH unexpected result at %0t", $time);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (red_out !== want.red) report_mismatch("red_out", red_out, want.red);
				if (green_out !== want.green)
					report_mismatch("green_out", green_out, want.green);
				if (blue_out !== want.blue) report_mismatch("blue_out", blue_out, want.blue);
				if (run_last !== want.run_last)
					report_mismatch("run_last", run_last, want.run_last);
				if (row_end !== want.row_end) report_mismatch("row_end", row_end, want.row_end);
				if (image_end !== want.image_end)
					report_mismatch("image_end", image_end, want.image_end);
			end
		end
	end

	// Watchdog on cycles without any accepted item or result
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		pix_valid = 1'b0;
		action = ACT_PIXEL;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		calm = 0;
		in_row = 0;
		in_col = 0;
		drain_col = 0;
		drain_on = 0;
		win_cols = '0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		foreach (older_px[k]) begin
			older_px[k] = '0;
			newer_px[k] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_height_change();
		test_random_images();

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
